>>> sv/clt_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the loop-detect endpoint table
// no dependencies

package clt_pkg;

    localparam int unsigned ACTION_W  = 2;
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned ADDR_W    = 64;
    localparam int unsigned AGE_W     = 5;
    localparam int unsigned IPV4_W    = 32;

    localparam logic [AGE_W-1:0] AGE_MAX       = 5'd31;
    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 5'd15;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    // one beat as it travels down the row of slots
    typedef struct packed {
        logic                valid;
        logic [ACTION_W-1:0] action;
        logic                is_ipv6;
        logic [PORT_W-1:0]   port;
        logic [ADDR_W-1:0]   addr_high;
        logic [ADDR_W-1:0]   addr_low;
        logic                placed;
        logic                found;
    } t_beat;

endpackage

>>> sv/clt_in_if.sv
`timescale 1ns / 1ps
// request channel of the loop-detect endpoint table
// depends on clt_pkg

interface clt_in_if
    import clt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                is_ipv6;
    logic [PORT_W-1:0]   port;
    logic [ADDR_W-1:0]   addr_high;
    logic [ADDR_W-1:0]   addr_low;

    modport source (
        output valid, action, is_ipv6, port, addr_high, addr_low,
        input  ready
    );
    modport sink (
        input  valid, action, is_ipv6, port, addr_high, addr_low,
        output ready
    );
endinterface

>>> sv/clt_out_if.sv
`timescale 1ns / 1ps
// result channel of the loop-detect endpoint table
// no dependencies

interface clt_out_if;
    logic valid;
    logic ready;
    logic loop_found;
    logic status;

    modport source (
        output valid, loop_found, status,
        input  ready
    );
    modport sink (
        input  valid, loop_found, status,
        output ready
    );
endinterface

>>> sv/connection_loop_detect_table.sv
`timescale 1ns / 1ps
// loop-detect endpoint table: a row of slot cells that each request passes through
// depends on clt_pkg, clt_in_if, clt_out_if, clt_cell
//
//  channel   dir   handshake        payload
//  i_in      in    valid / ready    action, is_ipv6, port, addr_high, addr_low
//  o_out     out   valid / ready    loop_found, status
//  cfg       in    i_cfg_we         i_cfg_data (timeout_seconds)
//
// a beat walks the row one slot per cycle while the row moves, and its result leaves
// from the last slot; a new beat can be taken every cycle that the row moves
// the row moves as a whole; it stops only while the result at the end waits
// reset clears all slots and sets the timeout to 15 seconds

module connection_loop_detect_table
    import clt_pkg::*;
#(
    parameter int unsigned ENTRIES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    clt_in_if.sink           i_in,
    clt_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [AGE_W-1:0] i_cfg_data
);

    logic [AGE_W-1:0] r_timeout;
    logic             w_advance;
    t_beat            w_beat [ENTRIES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_data;
        end
    end

    assign w_advance = !w_beat[ENTRIES].valid || o_out.ready;
    assign i_in.ready = w_advance;

    always_comb begin
        w_beat[0].valid     = i_in.valid;
        w_beat[0].action    = i_in.action;
        w_beat[0].is_ipv6   = i_in.is_ipv6;
        w_beat[0].port      = i_in.port;
        w_beat[0].addr_high = i_in.addr_high;
        w_beat[0].addr_low  = i_in.addr_low;
        w_beat[0].placed    = 1'b0;
        w_beat[0].found     = 1'b0;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        clt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_timeout (r_timeout),
            .i_beat    (w_beat[g]),
            .o_beat    (w_beat[g+1])
        );
    end

    assign o_out.valid      = w_beat[ENTRIES].valid;
    assign o_out.loop_found = w_beat[ENTRIES].found;
    assign o_out.status     = (w_beat[ENTRIES].action == ACT_ADD) && !w_beat[ENTRIES].placed;

    a_status_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status |-> w_beat[ENTRIES].action == ACT_ADD)
        else $error("full status on a beat that is not an add");

    a_found_only_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.loop_found |-> w_beat[ENTRIES].action == ACT_CHECK)
        else $error("loop found on a beat that is not a check");

    a_placed_only_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && w_beat[ENTRIES].placed |-> w_beat[ENTRIES].action == ACT_ADD)
        else $error("slot written by a beat that is not an add");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out.valid)
        else $error("result beat right after reset");

endmodule

>>> sv/clt_cell.sv
`timescale 1ns / 1ps
// one table slot: stores an endpoint and its age, acts on the beat passing by
// depends on clt_pkg

module clt_cell
    import clt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [AGE_W-1:0] i_timeout,
    input  t_beat            i_beat,
    output t_beat            o_beat
);

    logic              r_valid;
    logic              r_family;
    logic [PORT_W-1:0] r_port;
    logic [ADDR_W-1:0] r_addr_high;
    logic [ADDR_W-1:0] r_addr_low;
    logic [AGE_W-1:0]  r_age;
    t_beat             r_beat;

    logic              n_valid;
    logic              n_family;
    logic [PORT_W-1:0] n_port;
    logic [ADDR_W-1:0] n_addr_high;
    logic [ADDR_W-1:0] n_addr_low;
    logic [AGE_W-1:0]  n_age;
    t_beat             n_beat;

    logic w_expired;
    logic w_match;

    assign w_expired = r_age > i_timeout;

    always_comb begin
        w_match = (r_family == i_beat.is_ipv6) && (r_port == i_beat.port);
        if (i_beat.is_ipv6) begin
            w_match = w_match && (r_addr_high == i_beat.addr_high)
                              && (r_addr_low == i_beat.addr_low);
        end else begin
            w_match = w_match && (r_addr_low[IPV4_W-1:0] == i_beat.addr_low[IPV4_W-1:0]);
        end
    end

    always_comb begin
        n_valid     = r_valid;
        n_family    = r_family;
        n_port      = r_port;
        n_addr_high = r_addr_high;
        n_addr_low  = r_addr_low;
        n_age       = r_age;
        n_beat      = i_beat;
        if (i_beat.valid) begin
            unique case (t_action'(i_beat.action))
                ACT_ADD: begin
                    if (!i_beat.placed && (!r_valid || w_expired)) begin
                        n_valid       = 1'b1;
                        n_family      = i_beat.is_ipv6;
                        n_port        = i_beat.port;
                        n_addr_high   = i_beat.addr_high;
                        n_addr_low    = i_beat.addr_low;
                        n_age         = '0;
                        n_beat.placed = 1'b1;
                    end
                end
                ACT_CHECK: begin
                    if (r_valid) begin
                        if (w_expired) begin
                            n_valid = 1'b0;
                        end else if (w_match) begin
                            n_beat.found = 1'b1;
                        end
                    end
                end
                ACT_TICK: begin
                    if (r_valid && (r_age < AGE_MAX)) begin
                        n_age = r_age + AGE_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_beat.valid <= 1'b0;
        end else if (i_advance) begin
            r_valid     <= n_valid;
            r_family    <= n_family;
            r_port      <= n_port;
            r_addr_high <= n_addr_high;
            r_addr_low  <= n_addr_low;
            r_age       <= n_age;
            r_beat      <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule
